// File: hdl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the push-to-talk gesture detector.
// ----------------------------------------------------------------------------
package ptt_pkg;

  // recording mode codes
  localparam logic [1:0] MODE_STANDBY = 2'd0;
  localparam logic [1:0] MODE_HOLD    = 2'd1;
  localparam logic [1:0] MODE_LATCH   = 2'd2;

  // configuration register indexes
  localparam logic CFG_HOLD_MS       = 1'b0;
  localparam logic CFG_TAP_WINDOW_MS = 1'b1;

  // configuration reset values
  localparam logic [15:0] HOLD_MS_RESET       = 16'd250;
  localparam logic [15:0] TAP_WINDOW_MS_RESET = 16'd400;

  // gesture tracking state carried from sample to sample
  typedef struct packed {
    logic [1:0]  rec_mode;
    logic        prev_button;
    logic        prev_link;
    logic [15:0] press_timer;
    logic [15:0] tap_gap_timer;
    logic        first_tap_seen;
    logic [31:0] record_timer;
    logic [31:0] clip_length;
  } gesture_state_t;

  // sample fields
  typedef struct packed {
    logic       button_down;
    logic       link_up;
    logic [7:0] elapsed_ms;
  } sample_t;

endpackage

// File: hdl/push_to_talk_gesture_fsm_unit.sv
// ----------------------------------------------------------------------------
// push_to_talk_gesture_fsm_unit
// Tap, hold and double-tap detector driving a push-to-talk hotkey.
// ----------------------------------------------------------------------------
// Takes one sample per clock while in_ready is high (button level, link
// level, elapsed ms) and gives one result per sample, in the cycle after
// the sample transaction, from the output register. The sample path is a
// single pass of adders and compares between the state registers and the
// output register, so a new sample is accepted every cycle while the output
// register is empty or being drained in the same cycle. Configuration writes
// are always accepted and take effect for the next sample.
module push_to_talk_gesture_fsm_unit (
  input  logic        clk,
  input  logic        rst,
  // sample channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        button_down,
  input  logic        link_up,
  input  logic [7:0]  elapsed_ms,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        combo_held,
  output logic [1:0]  state_code,
  output logic        linked,
  output logic        tap_pending,
  output logic [31:0] recording_ms,
  output logic [31:0] last_clip_ms,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import ptt_pkg::*;

  gesture_state_t state;
  gesture_state_t state_next;
  sample_t        sample;
  logic [15:0]    hold_ms;
  logic [15:0]    tap_window_ms;
  logic           in_fire;
  logic           recording_next;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~out_valid | out_ready;
  assign in_fire   = in_valid & in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ms       <= HOLD_MS_RESET;
      tap_window_ms <= TAP_WINDOW_MS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_HOLD_MS:       hold_ms       <= cfg_data;
        CFG_TAP_WINDOW_MS: tap_window_ms <= cfg_data;
        default:           ;
      endcase
    end
  end

  // next-state logic for the incoming sample
  assign sample.button_down = button_down;
  assign sample.link_up     = link_up;
  assign sample.elapsed_ms  = elapsed_ms;

  ptt_step u_step (
    .cur           (state),
    .sample        (sample),
    .hold_ms       (hold_ms),
    .tap_window_ms (tap_window_ms),
    .nxt           (state_next)
  );

  // gesture state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  assign recording_next = (state_next.rec_mode != MODE_STANDBY);

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      combo_held   <= recording_next;
      state_code   <= state_next.rec_mode;
      linked       <= state_next.prev_link;
      tap_pending  <= state_next.first_tap_seen;
      recording_ms <= recording_next ? state_next.record_timer : 32'd0;
      last_clip_ms <= state_next.clip_length;
    end
  end

  // idle result shows no recording
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (out_valid && state_code == MODE_STANDBY) |-> (recording_ms == 32'd0 && !combo_held))
    else $error("idle result shows recording activity");

  // hotkey held exactly while recording
  a_combo_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (combo_held == (state_code != MODE_STANDBY)))
    else $error("combo_held disagrees with state_code");

  // link down forces idle with no pending tap
  a_link_down_idle: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !link_up) |=> (state_code == MODE_STANDBY && !tap_pending && !linked))
    else $error("gesture active while link down");

  // every sample transaction yields a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid)
    else $error("sample transaction without result");

endmodule

// File: hdl/ptt_step.sv
// ----------------------------------------------------------------------------
// ptt_step
// Next-state logic for one sample: timer advance, link edges, hold check,
// release handling and tap expiry.
// ----------------------------------------------------------------------------
module ptt_step (
  input  ptt_pkg::gesture_state_t cur,
  input  ptt_pkg::sample_t        sample,
  input  logic [15:0]             hold_ms,
  input  logic [15:0]             tap_window_ms,
  output ptt_pkg::gesture_state_t nxt
);
  import ptt_pkg::*;

  logic        pressed_edge;
  logic        released_edge;
  logic [16:0] press_sum;
  logic [16:0] gap_sum;
  logic [32:0] rec_sum;
  logic [15:0] press_adv;
  logic [15:0] gap_adv;
  logic [31:0] rec_adv;
  logic        recording_in;

  // edges against the previous sample
  assign pressed_edge  = sample.button_down & ~cur.prev_button;
  assign released_edge = ~sample.button_down & cur.prev_button;
  assign recording_in  = (cur.rec_mode != MODE_STANDBY);

  // saturating timer advance
  assign press_sum = {1'b0, cur.press_timer} + {9'd0, sample.elapsed_ms};
  assign gap_sum   = {1'b0, cur.tap_gap_timer} + {9'd0, sample.elapsed_ms};
  assign rec_sum   = {1'b0, cur.record_timer} + {25'd0, sample.elapsed_ms};
  assign press_adv = press_sum[16] ? 16'hFFFF : press_sum[15:0];
  assign gap_adv   = gap_sum[16] ? 16'hFFFF : gap_sum[15:0];
  assign rec_adv   = rec_sum[32] ? 32'hFFFF_FFFF : rec_sum[31:0];

  // gesture decisions in sample order
  always_comb begin
    nxt = cur;
    nxt.press_timer   = press_adv;
    nxt.tap_gap_timer = gap_adv;
    if (recording_in) begin
      nxt.record_timer = rec_adv;
    end

    // link edges
    if (sample.link_up && !cur.prev_link) begin
      if (recording_in) begin
        nxt.clip_length = nxt.record_timer;
      end
      nxt.rec_mode       = MODE_STANDBY;
      nxt.first_tap_seen = 1'b0;
    end else if (!sample.link_up && cur.prev_link) begin
      nxt.rec_mode       = MODE_STANDBY;
      nxt.first_tap_seen = 1'b0;
    end
    nxt.prev_link   = sample.link_up;
    nxt.prev_button = sample.button_down;

    // gestures only with the link up
    if (sample.link_up) begin
      if (pressed_edge) begin
        nxt.press_timer = '0;
      end
      if (nxt.rec_mode == MODE_STANDBY && sample.button_down &&
          nxt.press_timer >= hold_ms) begin
        nxt.record_timer = '0;
        nxt.rec_mode     = MODE_HOLD;
      end
      if (released_edge) begin
        if (nxt.rec_mode != MODE_STANDBY) begin
          nxt.clip_length    = nxt.record_timer;
          nxt.rec_mode       = MODE_STANDBY;
          nxt.first_tap_seen = 1'b0;
        end else if (nxt.press_timer < hold_ms) begin
          if (nxt.first_tap_seen && nxt.tap_gap_timer <= tap_window_ms) begin
            nxt.record_timer   = '0;
            nxt.rec_mode       = MODE_LATCH;
            nxt.first_tap_seen = 1'b0;
          end else begin
            nxt.first_tap_seen = 1'b1;
            nxt.tap_gap_timer  = '0;
          end
        end
      end
      // lone tap expires
      if (nxt.first_tap_seen && nxt.tap_gap_timer > tap_window_ms) begin
        nxt.first_tap_seen = 1'b0;
      end
    end
  end

endmodule
